// File: rtl/h2416_pkg.sv
// shared types, constants and the nibble parity function of the hamming 24/16 encoder
// depends on nothing; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package h2416_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned NIB_W = 4;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam logic [BYTE_W-1:0] PAD_RESET = 8'hff;

	// per-bit codes, bit 0 to bit 7
	localparam logic [NIB_W-1:0] BIT_CODE [BYTE_W] = '{
		4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12
	};

	// one closed pair waiting to be serialized
	typedef struct packed {
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
		logic [BYTE_W-1:0] parity;
		logic              eom;
	} pair_t;

	// front status seen by the top level
	typedef struct packed {
		logic holding;
		logic pair_push;
	} front_sts_t;

	function automatic logic [NIB_W-1:0] nibble_parity(input logic [BYTE_W-1:0] b);
		logic [NIB_W-1:0] p;
		p = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			if (b[k]) begin
				p = p ^ BIT_CODE[k];
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// File: rtl/h2416_stream_if.sv
// valid/ready channel interfaces for message bytes in and code bytes out
// depends on h2416_pkg
`timescale 1ns / 1ps
`default_nettype none

interface h2416_in_if;
	logic                          valid;
	logic                          ready;
	logic [h2416_pkg::BYTE_W-1:0]  data_byte;
	logic                          last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface h2416_out_if;
	logic                          valid;
	logic                          ready;
	logic [h2416_pkg::BYTE_W-1:0]  code_byte;
	logic                          is_parity;
	logic                          end_of_message;

	modport source (output valid, output code_byte, output is_parity, output end_of_message,
		input ready);
	modport sink (input valid, input code_byte, input is_parity, input end_of_message,
		output ready);
endinterface

`default_nettype wire

// File: rtl/h2416_front.sv
// front end: takes message bytes, pairs them, pads odd endings, computes parity
// depends on h2416_pkg and h2416_in_if
`timescale 1ns / 1ps
`default_nettype none

module h2416_front (
	input  wire                           clk,
	input  wire                           arst_n,
	h2416_in_if.sink                      din,
	input  wire                           pad_value_we,
	input  wire [h2416_pkg::BYTE_W-1:0]   pad_value,
	output logic                          push_valid,
	input  wire                           push_ready,
	output h2416_pkg::pair_t              push_data,
	output h2416_pkg::front_sts_t         sts
);

	logic [h2416_pkg::BYTE_W-1:0] pad_q;
	logic [h2416_pkg::BYTE_W-1:0] held_q;
	logic                         holding_q;
	logic                         accept;
	logic [h2416_pkg::BYTE_W-1:0] first_b;
	logic [h2416_pkg::BYTE_W-1:0] second_b;

	assign din.ready = push_ready;
	assign accept = din.valid && din.ready;

	// a pair closes on the partner byte or on an unpaired final byte
	assign push_valid = din.valid && (holding_q || din.last_byte);
	assign first_b = holding_q ? held_q : din.data_byte;
	assign second_b = holding_q ? din.data_byte : pad_q;

	always_comb begin
		push_data.first = first_b;
		push_data.second = second_b;
		push_data.parity = {h2416_pkg::nibble_parity(second_b),
			h2416_pkg::nibble_parity(first_b)};
		push_data.eom = holding_q ? din.last_byte : 1'b1;
	end

	assign sts.holding = holding_q;
	assign sts.pair_push = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= h2416_pkg::PAD_RESET;
			held_q <= '0;
			holding_q <= 1'b0;
		end else begin
			if (pad_value_we) begin
				pad_q <= pad_value;
			end
			if (accept && !holding_q) begin
				held_q <= din.data_byte;
			end
			if (accept) begin
				holding_q <= !holding_q && !din.last_byte;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/h2416_queue.sv
// small queue of closed pairs between front and back
// depends on h2416_pkg
`timescale 1ns / 1ps
`default_nettype none

module h2416_queue #(
	parameter int unsigned DEPTH = h2416_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push_valid,
	output logic                   push_ready,
	input  h2416_pkg::pair_t       push_data,
	output logic                   pop_valid,
	input  wire                    pop_ready,
	output h2416_pkg::pair_t       pop_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	h2416_pkg::pair_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign count = cnt_q;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/h2416_back.sv
// back end: serializes each pair into first, second and parity bytes
// depends on h2416_pkg and h2416_out_if
`timescale 1ns / 1ps
`default_nettype none

module h2416_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 pop_valid,
	output logic                pop_ready,
	input  h2416_pkg::pair_t    pop_data,
	h2416_out_if.source         dout
);

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_PARITY
	} phase_t;

	phase_t                       phase_q;
	logic                         out_vld_q;
	logic [h2416_pkg::BYTE_W-1:0] code_q;
	logic                         par_q;
	logic                         eom_q;
	logic                         load;
	logic [h2416_pkg::BYTE_W-1:0] sel_byte;

	assign load = pop_valid && (!out_vld_q || dout.ready);
	assign pop_ready = load && (phase_q == PH_PARITY);

	always_comb begin
		unique case (phase_q)
			PH_FIRST:  sel_byte = pop_data.first;
			PH_SECOND: sel_byte = pop_data.second;
			PH_PARITY: sel_byte = pop_data.parity;
			default:   sel_byte = pop_data.first;
		endcase
	end

	assign dout.valid = out_vld_q;
	assign dout.code_byte = code_q;
	assign dout.is_parity = par_q;
	assign dout.end_of_message = eom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				unique case (phase_q)
					PH_FIRST:  phase_q <= PH_SECOND;
					PH_SECOND: phase_q <= PH_PARITY;
					PH_PARITY: phase_q <= PH_FIRST;
					default:   phase_q <= PH_FIRST;
				endcase
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= sel_byte;
			par_q <= (phase_q == PH_PARITY);
			eom_q <= (phase_q == PH_PARITY) && pop_data.eom;
		end
	end

endmodule

`default_nettype wire

// File: rtl/hamming_24_16_stream_encoder_core.sv
// top level of the hamming 24/16 byte-pair stream encoder
// depends on h2416_pkg, h2416_stream_if, h2416_front, h2416_queue, h2416_back
`timescale 1ns / 1ps
`default_nettype none

// Message bytes enter on din one at a time and are grouped into pairs; each
// pair leaves on dout as three bytes: the first byte, the second byte, then a
// parity byte whose low nibble is the hamming parity of the first byte and
// whose high nibble that of the second. A final byte without a partner is
// paired with pad_value (0xff after reset, written through pad_value_we).
// The front takes one byte per cycle while the pair queue has room and closes
// a pair in the same cycle its second byte arrives. The back sends one byte
// per cycle while the receiver is ready, from a registered output stage;
// each pair costs three output bytes and sustained throughput is set by the
// one-byte output port. A closing pair passes the pair queue, then the output
// register. pad_value may be written only while no pair is in flight.
module hamming_24_16_stream_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = h2416_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	h2416_in_if.sink                      din,
	h2416_out_if.source                   dout,
	input  wire                           pad_value_we,
	input  wire [h2416_pkg::BYTE_W-1:0]   pad_value
);

	// front to queue
	logic                       push_valid;
	logic                       push_ready;
	h2416_pkg::pair_t           push_data;
	h2416_pkg::front_sts_t      front_sts;

	// queue to back
	logic                       pop_valid;
	logic                       pop_ready;
	h2416_pkg::pair_t           pop_data;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	// pairing, padding and parity
	h2416_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.din          (din),
		.pad_value_we (pad_value_we),
		.pad_value    (pad_value),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data),
		.sts          (front_sts)
	);

	// decouples input bursts from the three-byte output pace
	h2416_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.count      (q_count)
	);

	// byte serializer with output register
	h2416_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.dout      (dout)
	);

	// end of message only ever rides on a parity byte
	a_eom_on_parity: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.end_of_message |-> dout.is_parity)
		else $error("end_of_message on a data byte");

	// queue occupancy stays within its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("pair queue overflow");

	// an open non-final byte is held for its partner
	a_hold_open: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready && !front_sts.holding && !din.last_byte
		|=> front_sts.holding)
		else $error("unpaired byte not held");

	// a pair is pushed only when it closes, which always releases the held byte
	a_push_releases: assert property (@(posedge clk) disable iff (!arst_n)
		front_sts.pair_push |=> !front_sts.holding)
		else $error("byte still held after pair closed");

	// parity bytes never come back to back
	a_parity_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.ready && dout.is_parity |=> !(dout.valid && dout.is_parity))
		else $error("two parity bytes in a row");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench of the hamming 24/16 byte-pair stream encoder
// depends on h2416_pkg, h2416_stream_if and hamming_24_16_stream_encoder_core
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned BYTE_W = h2416_pkg::BYTE_W;
	localparam int unsigned NIB_W = h2416_pkg::NIB_W;
	localparam logic [BYTE_W-1:0] PAD_RESET = h2416_pkg::PAD_RESET;

	// generous cycle budget, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 200000;
	// quiet cycles after the last code byte, covers the output register
	localparam int unsigned SETTLE_CYCLES = 8;
	// length of the long receiver hold-off in the pressure test
	localparam int unsigned HOLD_OFF_CYCLES = 300;

	// one expected code byte on the output channel
	typedef struct {
		logic [BYTE_W-1:0] code;
		logic              parity;
		logic              eom;
	} code_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic pad_value_we;
	logic [BYTE_W-1:0] pad_value;

	h2416_in_if  din_if ();
	h2416_out_if dout_if ();

	hamming_24_16_stream_encoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.din          (din_if),
		.dout         (dout_if),
		.pad_value_we (pad_value_we),
		.pad_value    (pad_value)
	);

	always #5 clk = ~clk;

	// expected code bytes, oldest first
	code_item_t expected_codes[$];

	// shadow of the encoder state and its pad register
	logic [BYTE_W-1:0] shadow_pad;
	logic [BYTE_W-1:0] shadow_held;
	logic              shadow_holding;

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// idling flag shared by sender and receiver, hold and gap counts of the receiver
	bit idling_on = 1'b0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned gap_left = 0;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// hamming nibble of one byte: each parity bit covers a fixed set of
	// data bits, which is the per-bit code table read column by column
	function automatic logic [NIB_W-1:0] hamming_nibble(input logic [BYTE_W-1:0] b);
		logic [NIB_W-1:0] p;
		p[0] = ^(b & 8'h5b);
		p[1] = ^(b & 8'h6d);
		p[2] = ^(b & 8'h8e);
		p[3] = ^(b & 8'hf0);
		return p;
	endfunction

	// queue the three code bytes of one closed pair
	task automatic push_pair(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
		input logic eom);
		code_item_t c;
		c.code = first;
		c.parity = 1'b0;
		c.eom = 1'b0;
		expected_codes.push_back(c);
		c.code = second;
		expected_codes.push_back(c);
		c.code = {hamming_nibble(second), hamming_nibble(first)};
		c.parity = 1'b1;
		c.eom = eom;
		expected_codes.push_back(c);
	endtask

	// advance the shadow state by one accepted message byte
	task automatic predict_code_bytes(input logic [BYTE_W-1:0] b, input logic last);
		if (shadow_holding) begin
			// a held byte always pairs with the next one, even across messages
			shadow_holding = 1'b0;
			push_pair(shadow_held, b, last);
		end else if (last) begin
			// odd final byte takes the pad value as its partner
			push_pair(b, shadow_pad, 1'b1);
		end else begin
			shadow_held = b;
			shadow_holding = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// every accepted code byte is compared with the oldest expectation
	always @(posedge clk) begin
		code_item_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (expected_codes.size() == 0) begin
				report_mismatch($sformatf("unexpected item code_byte %02h",
					dout_if.code_byte));
			end else begin
				want = expected_codes.pop_front();
				if (dout_if.code_byte !== want.code) begin
					report_mismatch($sformatf("code_byte expected %02h got %02h",
						want.code, dout_if.code_byte));
				end
				if (dout_if.is_parity !== want.parity) begin
					report_mismatch($sformatf("is_parity expected %0b got %0b",
						want.parity, dout_if.is_parity));
				end
				if (dout_if.end_of_message !== want.eom) begin
					report_mismatch($sformatf("end_of_message expected %0b got %0b",
						want.eom, dout_if.end_of_message));
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// receiver: random ready bursts plus an on-demand long hold-off
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else if (hold_request != 0) begin
			// long stall so the pair queue fills and the input backs up
			hold_left = hold_request;
			hold_request = 0;
			dout_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			dout_if.ready <= 1'b0;
		end else if (gap_left != 0) begin
			gap_left--;
			dout_if.ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			// start a random burst with ready low, this cycle included
			gap_left = $urandom_range(1, 7) - 1;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// sender and register access, all entered right after a rising edge
	// ------------------------------------------------------------------

	// offer one message byte and wait for its handshake
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			din_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.data_byte <= b;
		din_if.last_byte <= last;
		do @(posedge clk); while (!din_if.ready);
		predict_code_bytes(b, last);
	endtask

	// mostly random bytes, with the two extremes showing up often
	function automatic logic [BYTE_W-1:0] random_byte();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			send_byte(random_byte(), i == len - 1);
		end
	endtask

	// stop offering, wait for every expected byte, then let the block settle
	task automatic drain_outputs();
		din_if.valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pad register is only touched while the encoder is idle
	task automatic write_pad_value(input logic [BYTE_W-1:0] v);
		drain_outputs();
		pad_value_we <= 1'b1;
		pad_value <= v;
		@(posedge clk);
		pad_value_we <= 1'b0;
		shadow_pad = v;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// odd single byte right after reset must use the reset pad value
	task automatic test_reset_pad();
		send_byte(8'h3c, 1'b1);
	endtask

	// all-zero and all-one bytes, alternating patterns, single bits
	task automatic test_field_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
	endtask

	// pad register at both extremes and a mixed value
	task automatic test_pad_register();
		write_pad_value(8'h00);
		send_byte(8'ha5, 1'b1);
		write_pad_value(8'h5a);
		send_byte(8'hff, 1'b1);
		write_pad_value(8'hff);
		send_byte(8'h00, 1'b1);
	endtask

	// a held byte closes with the next byte whatever message it starts
	task automatic test_pair_across_messages();
		send_byte(8'hc3, 1'b0);
		send_byte(8'h3c, 1'b0);
		send_byte(8'h7e, 1'b0);
		send_byte(8'h81, 1'b1);
		send_byte(8'h12, 1'b1);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_output_backpressure();
		drain_outputs();
		idling_on = 1'b0;
		hold_request = HOLD_OFF_CYCLES;
		for (int i = 0; i < 6; i++) begin
			send_message(4);
		end
		drain_outputs();
	endtask

	// random phases, each with its own pad value; mostly well-formed
	// messages, some bytes with a random end mark as noise
	task automatic test_random_stream();
		int unsigned sent;
		int unsigned len;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				1: write_pad_value(8'h00);
				2: write_pad_value(8'hff);
				6: write_pad_value(8'h96);
				default: write_pad_value(BYTE_W'($urandom));
			endcase
			sent = 0;
			while (sent < 40) begin
				// last phase runs with no idling at all
				idling_on = (phase < 6) && ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 9) < 8) begin
					len = $urandom_range(1, 9);
					send_message(len);
					sent += len;
				end else begin
					send_byte(BYTE_W'($urandom), 1'($urandom));
					sent++;
				end
			end
			// close an open pair so the next register write finds it idle
			if (shadow_holding) begin
				send_byte(random_byte(), 1'b1);
			end
		end
		idling_on = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		din_if.valid = 1'b0;
		din_if.data_byte = '0;
		din_if.last_byte = 1'b0;
		dout_if.ready = 1'b0;
		pad_value_we = 1'b0;
		pad_value = PAD_RESET;
		arst_n = 1'b0;
		shadow_pad = PAD_RESET;
		shadow_held = '0;
		shadow_holding = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pad();
		idling_on = 1'b1;
		test_field_extremes();
		test_pad_register();
		test_pair_across_messages();
		test_output_backpressure();
		test_random_stream();

		drain_outputs();
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
